@@ src/lzwd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwd_pkg - shared types and constants for the LZW dictionary
// Field widths, command codes, register indexes and the controller states.
// ----------------------------------------------------------------------------
package lzwd_pkg;

  localparam int VALUE_W  = 12;  // stored code width
  localparam int PREFIX_W = 12;
  localparam int SYMBOL_W = 8;
  localparam int INUSE_W  = 13;
  localparam int FFC_W    = 9;
  localparam int CMD_W    = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SAVE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_MODE = 1'b1;

  localparam logic [FFC_W-1:0] FIRST_FREE_RST = 9'd257;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_CLEAR
  } state_t;

endpackage

@@ src/lzwd_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwd_table - code table storage
// Single-port-write, single-port-read synchronous RAM with a zeroing sweep
// after reset, one entry per cycle.
// ----------------------------------------------------------------------------
module lzwd_table
  import lzwd_pkg::*;
#(
  parameter int AW = 20
) (
  input  logic               clk,
  input  logic               rst,
  output logic               init_busy,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [VALUE_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [VALUE_W-1:0] rd_data
);

  localparam int DEPTH = 1 << AW;

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [AW-1:0]      sweep_addr;

  // zeroing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      init_busy  <= 1'b1;
      sweep_addr <= '0;
    end else if (init_busy) begin
      sweep_addr <= sweep_addr + 1'b1;
      if (&sweep_addr) begin
        init_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (init_busy) begin
      mem[sweep_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // controller must hold off while the sweep runs
  a_no_access_in_sweep: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> (!wr_en && !rd_en))
    else $error("table accessed during zeroing sweep");

endmodule

@@ src/lzw_direct_index_dictionary_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_direct_index_dictionary_unit - LZW compressor dictionary, direct table
// Table indexed by {adjusted prefix, symbol}; lookup, save and clear commands,
// with a used-entry list so a clear only zeroes entries that were written.
// ----------------------------------------------------------------------------
// Lookup: registered table read, then the result register.
// Save and unknown commands: result in the cycle after the request is taken.
// Clear: zeroes the table entries named by the first count used-list slots, one per
//   cycle, where count = min(codes_in_use - base_code, 2^CODE_BITS) in block mode.
// One request in flight at a time; the controller stalls requests outside its idle state.
// After reset the table is zeroed by a sweep over all 2^(CODE_BITS+8) entries
// (1,048,576 at CODE_BITS = 12); requests stall meanwhile, config writes don't.
module lzw_direct_index_dictionary_unit
  import lzwd_pkg::*;
#(
  parameter int CODE_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FFC_W-1:0]     cfg_data,
  // request channel
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic [CMD_W-1:0]     cmd,
  input  logic [PREFIX_W-1:0]  prefix_code,
  input  logic [SYMBOL_W-1:0]  symbol,
  input  logic [VALUE_W-1:0]   new_code,
  input  logic [INUSE_W-1:0]   codes_in_use,
  // result channel
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [VALUE_W-1:0]   found_code
);

  localparam int AW         = CODE_BITS + SYMBOL_W;   // table address width
  localparam int CW         = CODE_BITS + 1;          // clear count, holds list depth
  localparam int LIST_DEPTH = 1 << CODE_BITS;
  // scratch width for address / count math; wraps like the 32-bit original
  // in the low bits that we keep
  localparam int CALC_W     = ((CODE_BITS > INUSE_W) ? CODE_BITS : INUSE_W) + 1;
  localparam logic [CALC_W-1:0] LIST_DEPTH_C = CALC_W'(LIST_DEPTH);
  localparam logic [CALC_W-1:0] BYTE_CODES_C = CALC_W'(256);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [FFC_W-1:0] base_code;
  logic             keep_list;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_code <= FIRST_FREE_RST;
      keep_list <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST_FREE: base_code <= cfg_data;
        CFG_BLOCK_MODE: keep_list <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // address and count arithmetic on the request fields
  // --------------------------------------------------------------------------
  logic [CALC_W-1:0]    pfx_adj;
  logic [CALC_W-1:0]    pfx_sel;
  logic [AW-1:0]        entry_addr;
  logic [CALC_W-1:0]    pos_diff;
  logic [CODE_BITS-1:0] list_pos;
  logic [CALC_W-1:0]    clr_diff;
  logic [CALC_W-1:0]    clr_clamp;
  logic [CW-1:0]        clr_count;

  always_comb begin
    // dictionary codes drop the offset of the (possibly absent) clear code;
    // a base code below 256 turns this into an add, which is intended
    pfx_adj  = CALC_W'(prefix_code) + BYTE_CODES_C - CALC_W'(base_code);
    pfx_sel  = (prefix_code >= PREFIX_W'(base_code)) ? pfx_adj
                                                    : CALC_W'(prefix_code);
    entry_addr = {pfx_sel[CODE_BITS-1:0], symbol};

    // used-list slot wraps modulo the list depth
    pos_diff = CALC_W'(new_code) - CALC_W'(base_code);
    list_pos = pos_diff[CODE_BITS-1:0];

    // entries to wipe on clear, capped at the list depth
    clr_diff  = CALC_W'(codes_in_use) - CALC_W'(base_code);
    clr_clamp = (clr_diff > LIST_DEPTH_C) ? LIST_DEPTH_C : clr_diff;
    clr_count = (keep_list && (codes_in_use > INUSE_W'(base_code)))
                ? clr_clamp[CW-1:0] : '0;
  end

  // --------------------------------------------------------------------------
  // code table (RAM with its own reset sweep)
  // --------------------------------------------------------------------------
  logic               init_busy;
  logic               tbl_we;
  logic [AW-1:0]      tbl_wa;
  logic [VALUE_W-1:0] tbl_wd;
  logic               tbl_re;
  logic [VALUE_W-1:0] tbl_rd;

  lzwd_table #(
    .AW (AW)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .init_busy (init_busy),
    .wr_en     (tbl_we),
    .wr_addr   (tbl_wa),
    .wr_data   (tbl_wd),
    .rd_en     (tbl_re),
    .rd_addr   (entry_addr),
    .rd_data   (tbl_rd)
  );

  // --------------------------------------------------------------------------
  // used-entry list: written on save in block mode, read by the clear walk
  // --------------------------------------------------------------------------
  logic [AW-1:0] used_list [LIST_DEPTH];
  logic [AW-1:0] list_q;
  logic          list_we;
  logic          list_re;

  // --------------------------------------------------------------------------
  // controller
  // --------------------------------------------------------------------------
  state_t             state, state_next;
  logic [CW-1:0]      clr_cnt, clr_cnt_next;
  logic [CW-1:0]      clr_idx, clr_idx_next;
  logic               wipe_pend, wipe_pend_next;
  logic               load_res;
  logic [VALUE_W-1:0] res_data;
  logic               req_take;

  assign req_take = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (list_we) begin
      used_list[list_pos] <= entry_addr;
    end
    if (list_re) begin
      list_q <= used_list[clr_idx[CODE_BITS-1:0]];
    end
  end

  always_comb begin
    state_next     = state;
    clr_cnt_next   = clr_cnt;
    clr_idx_next   = clr_idx;
    wipe_pend_next = 1'b0;
    req_stall      = 1'b1;
    tbl_we         = 1'b0;
    tbl_wa         = entry_addr;
    tbl_wd         = new_code;
    tbl_re         = 1'b0;
    list_we        = 1'b0;
    list_re        = 1'b0;
    load_res       = 1'b0;
    res_data       = '0;

    unique case (state)
      ST_IDLE: begin
        // take a request once the sweep is done and the result slot is free or draining this cycle
        req_stall = init_busy || (res_valid && res_stall);
        if (req_valid && !req_stall) begin
          unique case (cmd)
            CMD_LOOKUP: begin
              tbl_re     = 1'b1;
              state_next = ST_LOOKUP;
            end
            CMD_SAVE: begin
              tbl_we   = 1'b1;
              list_we  = keep_list;
              load_res = 1'b1;
            end
            CMD_CLEAR: begin
              clr_cnt_next = clr_count;
              clr_idx_next = '0;
              state_next   = ST_CLEAR;
            end
            default: begin
              load_res = 1'b1;  // unknown command: no action, answer 0
            end
          endcase
        end
      end
      ST_LOOKUP: begin
        load_res   = 1'b1;
        res_data   = tbl_rd;
        state_next = ST_IDLE;
      end
      ST_CLEAR: begin
        // list read for slot i overlaps the table wipe for slot i-1
        if (clr_idx != clr_cnt) begin
          list_re        = 1'b1;
          clr_idx_next   = clr_idx + 1'b1;
          wipe_pend_next = 1'b1;
        end
        if (wipe_pend) begin
          tbl_we = 1'b1;
          tbl_wa = list_q;
          tbl_wd = '0;
        end
        if ((clr_idx == clr_cnt) && !wipe_pend) begin
          load_res   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wipe_pend <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      wipe_pend <= wipe_pend_next;
      if (load_res) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    clr_cnt <= clr_cnt_next;
    clr_idx <= clr_idx_next;
    if (load_res) begin
      found_code <= res_data;
    end
  end

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  a_lookup_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOKUP) |-> !res_valid)
    else $error("lookup data lands on an occupied result register");

  a_lookup_next: assert property (@(posedge clk) disable iff (rst)
    (req_take && (cmd == CMD_LOOKUP)) |=> (state == ST_LOOKUP))
    else $error("lookup did not move to data phase");

  a_no_req_in_sweep: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !req_take)
    else $error("request taken during table sweep");

  a_clear_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (clr_idx <= clr_cnt))
    else $error("clear walk index ran past its count");

endmodule

@@ verif/lzw_direct_index_dictionary_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_direct_index_dictionary_unit_tb - self-checking bench for the LZW dictionary
// Drives lookup, save and clear requests with random gaps and result stalls,
// mirrors the sparse code table and the used-entry list in the bench, and
// checks every found_code in order. A short directed table runs first, then
// LZW-like random traffic under several register settings.
// ----------------------------------------------------------------------------
module lzw_direct_index_dictionary_unit_tb;
  import lzwd_pkg::*;

  localparam int CODE_BITS  = 12;
  localparam int LIST_DEPTH = 1 << CODE_BITS;
  localparam int ADDR_W     = CODE_BITS + 8;

  // cmd value with no defined action; the block must answer 0 and change nothing
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  localparam int PRESSURE_AT     = 700;  // results seen before the long hold
  localparam int PRESSURE_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 320;
  localparam int DRAIN_LIMIT     = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [FFC_W-1:0]     cfg_data     = '0;
  logic                 req_valid    = 1'b0;
  logic                 req_stall;
  logic [CMD_W-1:0]     cmd          = '0;
  logic [PREFIX_W-1:0]  prefix_code  = '0;
  logic [SYMBOL_W-1:0]  symbol       = '0;
  logic [VALUE_W-1:0]   new_code     = '0;
  logic [INUSE_W-1:0]   codes_in_use = '0;
  logic                 res_valid;
  logic                 res_stall    = 1'b0;
  logic [VALUE_W-1:0]   found_code;

  lzw_direct_index_dictionary_unit #(
    .CODE_BITS(CODE_BITS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .cmd          (cmd),
    .prefix_code  (prefix_code),
    .symbol       (symbol),
    .new_code     (new_code),
    .codes_in_use (codes_in_use),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .found_code   (found_code)
  );

  // --------------------------------------------------------------------------
  // Dictionary mirror. The table is sparse, so only written entries are kept;
  // a missing key reads as 0 (undefined). used_written tracks which used-list
  // slots hold an address, so a clear never walks into an unwritten slot.
  // --------------------------------------------------------------------------
  bit [VALUE_W-1:0] dict_mirror [bit [ADDR_W-1:0]];
  bit [ADDR_W-1:0]  used_addr    [LIST_DEPTH];
  bit               used_written [LIST_DEPTH];
  logic [FFC_W-1:0] ffc_mirror   = FIRST_FREE_RST;
  logic             block_mirror = 1'b1;

  logic [VALUE_W-1:0] pending_found_codes [$];
  int fail_count    = 0;
  int results_seen  = 0;
  bit pressure_done = 0;
  int send_calm     = 0;

  typedef struct {
    logic [PREFIX_W-1:0] p;
    logic [SYMBOL_W-1:0] s;
  } string_key_t;

  typedef enum logic {ROW_REQ, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CMD_W-1:0]     c;
    logic [PREFIX_W-1:0]  p;
    logic [SYMBOL_W-1:0]  s;
    logic [VALUE_W-1:0]   nc;
    logic [INUSE_W-1:0]   iu;
    logic [CFG_IDX_W-1:0] ri;    // register rows only
    logic [FFC_W-1:0]     rv;
    bit                   typed; // want holds the expected found_code
    logic [VALUE_W-1:0]   want;
  } stim_row_t;

  // Directed table. Starts under the reset settings (first free 257, block
  // mode on). Typed answers: lookups of the cleared table, save, clear and
  // the unknown command, all 0. Everything else goes through the mirror.
  stim_row_t directed_rows [0:29] = '{
    '{ROW_REQ, CMD_LOOKUP,  12'd0,    8'd0,   12'd0,    13'd0,    CFG_FIRST_FREE, 9'd0,   1'b1, 12'd0},
    '{ROW_REQ, CMD_LOOKUP,  12'd4095, 8'd255, 12'd0,    13'd0,    CFG_FIRST_FREE, 9'd0,   1'b1, 12'd0},
    '{ROW_REQ, CMD_SAVE,    12'd65,   8'd66,  12'd257,  13'd0,    CFG_FIRST_FREE, 9'd0,   1'b1, 12'd0},
    '{ROW_REQ, CMD_LOOKUP,  12'd65,   8'd66,  12'd0,    13'd0,    CFG_FIRST_FREE, 9'd0,   1'b0, 12'd0},
    // dictionary prefix: offset applies, 257 and the clear code 256 alias
    '{ROW_REQ, CMD_SAVE,    12'd257,  8'd67,  12'd258,  13'd0,    CFG_FIRST_FREE, 9'd0,   1'b1, 12'd0},
    '{ROW_REQ, CMD_LOOKUP,  12'd256,  8'd67,  12'd0,    13'd0,    CFG_FIRST_FREE, 9'd0,   1'b0, 12'd0},
    '{ROW_REQ, CMD_SAVE,    12'd4095, 8'd255, 12'd4095, 13'd0,    CFG_FIRST_FREE, 9'd0,   1'b1, 12'd0},
    '{ROW_REQ, CMD_LOOKUP,  12'd4095, 8'd255, 12'd0,    13'd0,    CFG_FIRST_FREE, 9'd0,   1'b0, 12'd0},
    // code below first free: used-list slot wraps modulo the list depth (slot 3839)
    '{ROW_REQ, CMD_SAVE,    12'd0,    8'd0,   12'd0,    13'd0,    CFG_FIRST_FREE, 9'd0,   1'b1, 12'd0},
    '{ROW_REQ, CMD_SAVE,    12'd0,    8'd1,   12'd259,  13'd0,    CFG_FIRST_FREE, 9'd0,   1'b1, 12'd0},
    '{ROW_REQ, CMD_UNKNOWN, 12'd65,   8'd66,  12'd4095, 13'd4096, CFG_FIRST_FREE, 9'd0,   1'b1, 12'd0},
    '{ROW_REQ, CMD_LOOKUP,  12'd65,   8'd66,  12'd0,    13'd0,    CFG_FIRST_FREE, 9'd0,   1'b0, 12'd0},
    // codes_in_use below first free: clear resets nothing
    '{ROW_REQ, CMD_CLEAR,   12'd0,    8'd0,   12'd0,    13'd256,  CFG_FIRST_FREE, 9'd0,   1'b1, 12'd0},
    '{ROW_REQ, CMD_LOOKUP,  12'd65,   8'd66,  12'd0,    13'd0,    CFG_FIRST_FREE, 9'd0,   1'b0, 12'd0},
    '{ROW_REQ, CMD_CLEAR,   12'd0,    8'd0,   12'd0,    13'd260,  CFG_FIRST_FREE, 9'd0,   1'b1, 12'd0},
    '{ROW_REQ, CMD_LOOKUP,  12'd65,   8'd66,  12'd0,    13'd0,    CFG_FIRST_FREE, 9'd0,   1'b0, 12'd0},
    '{ROW_REQ, CMD_LOOKUP,  12'd4095, 8'd255, 12'd0,    13'd0,    CFG_FIRST_FREE, 9'd0,   1'b0, 12'd0},
    // no block mode: saves skip the list, clears are ignored
    '{ROW_REG, CMD_LOOKUP,  12'd0,    8'd0,   12'd0,    13'd0,    CFG_BLOCK_MODE, 9'd0,   1'b0, 12'd0},
    '{ROW_REQ, CMD_SAVE,    12'd300,  8'd7,   12'd4000, 13'd0,    CFG_FIRST_FREE, 9'd0,   1'b1, 12'd0},
    '{ROW_REQ, CMD_CLEAR,   12'd0,    8'd0,   12'd0,    13'd4096, CFG_FIRST_FREE, 9'd0,   1'b1, 12'd0},
    '{ROW_REQ, CMD_LOOKUP,  12'd300,  8'd7,   12'd0,    13'd0,    CFG_FIRST_FREE, 9'd0,   1'b0, 12'd0},
    '{ROW_REG, CMD_LOOKUP,  12'd0,    8'd0,   12'd0,    13'd0,    CFG_BLOCK_MODE, 9'd1,   1'b0, 12'd0},
    '{ROW_REG, CMD_LOOKUP,  12'd0,    8'd0,   12'd0,    13'd0,    CFG_FIRST_FREE, 9'd256, 1'b0, 12'd0},
    '{ROW_REQ, CMD_SAVE,    12'd256,  8'd9,   12'd256,  13'd0,    CFG_FIRST_FREE, 9'd0,   1'b1, 12'd0},
    '{ROW_REQ, CMD_LOOKUP,  12'd256,  8'd9,   12'd0,    13'd0,    CFG_FIRST_FREE, 9'd0,   1'b0, 12'd0},
    // first free below 256: the offset adds to the prefix
    '{ROW_REG, CMD_LOOKUP,  12'd0,    8'd0,   12'd0,    13'd0,    CFG_FIRST_FREE, 9'd0,   1'b0, 12'd0},
    '{ROW_REQ, CMD_SAVE,    12'd5,    8'd0,   12'd77,   13'd0,    CFG_FIRST_FREE, 9'd0,   1'b1, 12'd0},
    '{ROW_REQ, CMD_LOOKUP,  12'd5,    8'd0,   12'd0,    13'd0,    CFG_FIRST_FREE, 9'd0,   1'b0, 12'd0},
    '{ROW_REQ, CMD_LOOKUP,  12'd4095, 8'd0,   12'd0,    13'd0,    CFG_FIRST_FREE, 9'd0,   1'b0, 12'd0},
    '{ROW_REG, CMD_LOOKUP,  12'd0,    8'd0,   12'd0,    13'd0,    CFG_FIRST_FREE, 9'd257, 1'b0, 12'd0}
  };

  // --------------------------------------------------------------------------
  // Clock, reset, watchdog
  // --------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // The watchdog allows for the post-reset table sweep plus all traffic, even
  // with the worst gaps, stalls and clears.
  initial begin
    #(64'd60_000_000);
    $display("lzw_direct_index_dictionary_unit regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Mirror of the block
  // --------------------------------------------------------------------------
  // Table address: dictionary prefixes lose the clear-code offset (mod 2^32),
  // then {prefix, symbol} is cut to the table size.
  function automatic bit [ADDR_W-1:0] entry_addr(input logic [PREFIX_W-1:0] p,
                                                 input logic [SYMBOL_W-1:0] s);
    bit [31:0] adj;
    adj = p;
    if (adj >= ffc_mirror) adj = adj - ({23'd0, ffc_mirror} - 32'd256);
    return {adj[CODE_BITS-1:0], s};
  endfunction

  // Applies one accepted request to the mirror, returns the found_code due.
  function automatic logic [VALUE_W-1:0] dictionary_answer(
      input logic [CMD_W-1:0] c, input logic [PREFIX_W-1:0] p,
      input logic [SYMBOL_W-1:0] s, input logic [VALUE_W-1:0] nc,
      input logic [INUSE_W-1:0] iu);
    bit [ADDR_W-1:0]    a;
    int unsigned        pos;
    int unsigned        cnt;
    logic [VALUE_W-1:0] ans;
    ans = '0;
    a   = entry_addr(p, s);
    case (c)
      CMD_LOOKUP: begin
        if (dict_mirror.exists(a)) ans = dict_mirror[a];
      end
      CMD_SAVE: begin
        if (block_mirror) begin
          pos = (int'(nc) - int'(ffc_mirror)) & (LIST_DEPTH - 1);
          used_addr[pos]    = a;
          used_written[pos] = 1'b1;
        end
        dict_mirror[a] = nc;
      end
      CMD_CLEAR: begin
        if (block_mirror && iu > ffc_mirror) begin
          cnt = iu - ffc_mirror;
          if (cnt > LIST_DEPTH) cnt = LIST_DEPTH;
          for (int i = 0; i < cnt; i++) begin
            if (dict_mirror.exists(used_addr[i])) dict_mirror.delete(used_addr[i]);
          end
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  // Caps a clear's codes_in_use so the walk stays inside written list slots.
  function automatic logic [INUSE_W-1:0] safe_in_use(input logic [INUSE_W-1:0] iu);
    int unsigned fill;
    fill = 0;
    while (fill < LIST_DEPTH && used_written[fill]) fill++;
    if (block_mirror && iu > ffc_mirror && int'(iu - ffc_mirror) > fill)
      return INUSE_W'(ffc_mirror + fill);
    return iu;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones, and calm stretches.
  function automatic int send_gap();
    int r;
    if (send_calm > 0) begin
      send_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      send_calm = 60;
      return 0;
    end
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: payload and valid change only at a clock edge, and only
  // once the previous request has been taken (or valid is low).
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [CMD_W-1:0] c, input logic [PREFIX_W-1:0] p,
                              input logic [SYMBOL_W-1:0] s, input logic [VALUE_W-1:0] nc,
                              input logic [INUSE_W-1:0] iu, input bit typed,
                              input logic [VALUE_W-1:0] want);
    int                 gap;
    logic [VALUE_W-1:0] ans;
    gap = send_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid    <= 1'b1;
    cmd          <= c;
    prefix_code  <= p;
    symbol       <= s;
    new_code     <= nc;
    codes_in_use <= iu;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    ans = dictionary_answer(c, p, s, nc, iu);
    pending_found_codes.push_back(typed ? want : ans);
  endtask

  // Block is idle once every answer is back; the task then waits on for the
  // result register to settle before touching the registers.
  task automatic wait_idle();
    req_valid <= 1'b0;
    while (pending_found_codes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FFC_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == CFG_FIRST_FREE) ffc_mirror = val;
    else block_mirror = val[0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [PREFIX_W-1:0] pick_prefix(input int code_cursor);
    if (code_cursor > int'(ffc_mirror) && $urandom_range(0, 1))
      return PREFIX_W'($urandom_range(int'(ffc_mirror), code_cursor - 1));
    return PREFIX_W'($urandom_range(0, 255));
  endfunction

  // --------------------------------------------------------------------------
  // Random traffic: mostly an LZW-shaped session (saves with rising codes,
  // hits on saved strings, misses, then a clear with codes_in_use at the
  // next code), plus raw noise over every field.
  // --------------------------------------------------------------------------
  task automatic run_traffic(input int n_items);
    string_key_t          known [$];
    string_key_t          k;
    int                   code_cursor;
    int                   epoch_len;
    int                   r;
    logic [CMD_W-1:0]     c;
    logic [PREFIX_W-1:0]  p;
    logic [SYMBOL_W-1:0]  s;
    logic [VALUE_W-1:0]   nc;
    logic [INUSE_W-1:0]   iu;
    bit                   end_epoch;
    code_cursor = ffc_mirror;
    epoch_len = $urandom_range(0, 9) == 0 ? $urandom_range(60, 300) : $urandom_range(4, 40);
    for (int n = 0; n < n_items; n++) begin
      r         = $urandom_range(0, 99);
      end_epoch = 1'b0;
      iu        = INUSE_W'($urandom_range(0, 4096));
      nc        = VALUE_W'($urandom_range(0, 4095));
      s         = SYMBOL_W'($urandom_range(0, 255));
      if (r < 35 && known.size() != 0) begin
        k = known[$urandom_range(0, known.size() - 1)];
        send_request(CMD_LOOKUP, k.p, k.s, nc, iu, 1'b0, '0);
      end else if (r < 55) begin
        send_request(CMD_LOOKUP, pick_prefix(code_cursor), s, nc, iu, 1'b0, '0);
      end else if (r < 75) begin
        if (code_cursor - int'(ffc_mirror) >= epoch_len || code_cursor >= 4095) begin
          end_epoch = 1'b1;
        end else begin
          k.p = pick_prefix(code_cursor);
          k.s = s;
          send_request(CMD_SAVE, k.p, k.s, VALUE_W'(code_cursor), iu, 1'b0, '0);
          known.push_back(k);
          code_cursor++;
        end
      end else if (r < 80) begin
        end_epoch = 1'b1;
      end else begin
        c = CMD_W'($urandom_range(0, 3));
        p = PREFIX_W'($urandom_range(0, 4095));
        if (c == CMD_CLEAR) iu = safe_in_use(iu);
        send_request(c, p, s, nc, iu, 1'b0, '0);
      end
      if (end_epoch) begin
        send_request(CMD_CLEAR, pick_prefix(code_cursor), s, nc,
                     safe_in_use(INUSE_W'(code_cursor)), 1'b0, '0);
        known.delete();
        code_cursor = ffc_mirror;
        epoch_len = $urandom_range(0, 9) == 0 ? $urandom_range(60, 300)
                                              : $urandom_range(4, 40);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [FFC_W-1:0] phase_ffc [6];
    logic             phase_blk [6];
    int               waited;
    phase_ffc = '{9'd257, 9'd256, 9'd511, 9'd256, 9'd257, 9'd0};
    phase_blk = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    phase_ffc[5] = FFC_W'($urandom_range(0, 511));
    while (rst) @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(directed_rows[i].ri, directed_rows[i].rv);
      end else begin
        send_request(directed_rows[i].c, directed_rows[i].p, directed_rows[i].s,
                     directed_rows[i].nc, directed_rows[i].iu,
                     directed_rows[i].typed, directed_rows[i].want);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      write_reg(CFG_FIRST_FREE, phase_ffc[ph]);
      write_reg(CFG_BLOCK_MODE, FFC_W'(phase_blk[ph]));
      run_traffic(ITEMS_PER_PHASE);
    end

    // drain, then a short tail so a stray extra result would still be seen
    req_valid <= 1'b0;
    waited = 0;
    while (pending_found_codes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_found_codes.size() != 0) begin
      $display("%0t: %0d found_code results never arrived", $time,
               pending_found_codes.size());
      fail_count++;
    end
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("lzw_direct_index_dictionary_unit regression: pass");
    end else begin
      $display("lzw_direct_index_dictionary_unit regression: fail");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random stall pattern, plus one long hold so requests back up
  // and req_stall has to assert.
  // --------------------------------------------------------------------------
  initial begin
    int r;
    while (rst) @(posedge clk);
    forever begin
      if (!pressure_done && results_seen >= PRESSURE_AT) begin
        res_stall <= 1'b1;
        repeat (PRESSURE_CYCLES) @(posedge clk);
        pressure_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          res_stall <= 1'b0;
          repeat (100) @(posedge clk);
        end else if (r < 60) begin
          res_stall <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end else if (r < 90) begin
          res_stall <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else if (r < 97) begin
          res_stall <= 1'b1;
          repeat ($urandom_range(4, 12)) @(posedge clk);
        end else begin
          res_stall <= 1'b1;
          repeat ($urandom_range(20, 60)) @(posedge clk);
        end
      end
    end
  end

  // Every taken result is matched against the oldest outstanding answer.
  always @(posedge clk) begin
    logic [VALUE_W-1:0] want;
    if (!rst && res_valid && !res_stall) begin
      results_seen++;
      if (pending_found_codes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual found_code %0d",
                 $time, found_code);
        fail_count++;
      end else begin
        want = pending_found_codes.pop_front();
        if (found_code !== want) begin
          $display("%0t: found_code mismatch, expected %0d, actual %0d",
                   $time, want, found_code);
          fail_count++;
        end
      end
    end
  end

endmodule
